@@ rtl/core/dotted_circle_point_generator_macros.svh @@
// ----------------------------------------------------------------------------
// dotted circle point generator assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DOTTED_CIRCLE_POINT_GENERATOR_MACROS_SVH
`define DOTTED_CIRCLE_POINT_GENERATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DCPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcpg assertion failed");

// consequent must hold in the cycle after the antecedent
`define DCPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcpg assertion failed");

`endif

@@ rtl/core/dcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// dcpg_pkg
// shared constants and types of the dotted circle point generator
// ----------------------------------------------------------------------------
package dcpg_pkg;

  // default coordinate width
  localparam int CoordBitsDef = 8;
  // radius field and step offsets
  localparam int RadiusBits   = 7;
  localparam int OffsetBits   = 8;
  // midpoint decision term, two's complement, wide enough for radius 127
  localparam int DecBits      = 11;
  localparam int StyleBits    = 2;
  // dots emitted by one plotted iteration
  localparam int DotsPerIter  = 8;
  localparam int BeatBits     = $clog2(DotsPerIter);
  // front to back job queue
  localparam int QueueDepth   = 2;

  // item kinds carried on tuser
  localparam logic ModeStart = 1'b0;
  localparam logic ModeStep  = 1'b1;

  // line style codes
  localparam logic [StyleBits-1:0] StyleFull  = 2'd0;
  localparam logic [StyleBits-1:0] StyleEven  = 2'd1;
  localparam logic [StyleBits-1:0] StyleOdd   = 2'd2;
  localparam logic [StyleBits-1:0] StyleThird = 2'd3;

  // per-job control flags handed from front to back
  typedef struct packed {
    logic dot;    // iteration passed the style filter, emit eight dots
    logic fin;    // circle finished with this iteration
    logic color;  // dot color
  } job_flags_t;

  localparam int FlagBits = $bits(job_flags_t);

endpackage

@@ rtl/core/dotted_circle_point_generator.sv @@
// Path: an accepted word passes through the job queue, the back end's job register
// and the output register before its first result word is on the result port.
// Throughput: one input word per cycle while the job queue has room; the dot
// emitter gives one result per cycle while the result port is not stalled; a
// plotted iteration gives eight result words, a filtered iteration or idle step one.
// Reset: asynchronous, active low; clears the circle state (idle), the queue
// and the output valid flag.
// ----------------------------------------------------------------------------
// dotted_circle_point_generator
// midpoint circle dot generator with line styles, front iterates and queues
// jobs, back end emits up to eight symmetric dots per job
// ----------------------------------------------------------------------------
module dotted_circle_point_generator import dcpg_pkg::*; #(
  parameter int CoordBits = CoordBitsDef,
  parameter int InDataW   = ((2 * CoordBits + RadiusBits + StyleBits + 1 + 7) / 8) * 8,
  parameter int OutDataW  = ((2 * CoordBits + 1 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // center_x, center_y, radius, line_style, draw_color, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // mode
  input  logic                s_axis_tuser_i,
  // result words
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // dot_x, dot_y, dot_color, zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // dot_valid, finished
  output logic [1:0]          m_axis_tuser_o,
  // last
  output logic                m_axis_tlast_o
);

  localparam int JobBits = 2 * CoordBits + 2 * OffsetBits + FlagBits;
  localparam int RadLo   = 2 * CoordBits;
  localparam int StyLo   = RadLo + RadiusBits;
  localparam int ColPos  = StyLo + StyleBits;

  logic               job_wr_valid, job_wr_ready;
  logic [JobBits-1:0] job_wr_data;
  logic               job_rd_valid, job_rd_ready;
  logic [JobBits-1:0] job_rd_data;

  logic [CoordBits-1:0] dot_x, dot_y;
  logic                 dot_color, dot_valid, dot_last, dot_fin;

  // iteration front
  dcpg_front #(
    .CoordBits (CoordBits),
    .JobBits   (JobBits)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .in_mode_i       (s_axis_tuser_i),
    .in_center_x_i   (s_axis_tdata_i[CoordBits-1:0]),
    .in_center_y_i   (s_axis_tdata_i[RadLo-1:CoordBits]),
    .in_radius_i     (s_axis_tdata_i[StyLo-1:RadLo]),
    .in_line_style_i (s_axis_tdata_i[ColPos-1:StyLo]),
    .in_draw_color_i (s_axis_tdata_i[ColPos]),
    .job_valid_o     (job_wr_valid),
    .job_ready_i     (job_wr_ready),
    .job_data_o      (job_wr_data)
  );

  // job queue
  dcpg_fifo #(
    .Width (JobBits),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (job_wr_valid),
    .wr_ready_o (job_wr_ready),
    .wr_data_i  (job_wr_data),
    .rd_valid_o (job_rd_valid),
    .rd_ready_i (job_rd_ready),
    .rd_data_o  (job_rd_data)
  );

  // dot emitter
  dcpg_back #(
    .CoordBits (CoordBits),
    .JobBits   (JobBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_rd_valid),
    .job_ready_o     (job_rd_ready),
    .job_data_i      (job_rd_data),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_dot_x_o     (dot_x),
    .out_dot_y_o     (dot_y),
    .out_dot_color_o (dot_color),
    .out_dot_valid_o (dot_valid),
    .out_last_o      (dot_last),
    .out_finished_o  (dot_fin)
  );

  // result word packing
  assign m_axis_tdata_o = OutDataW'({dot_color, dot_y, dot_x});
  assign m_axis_tuser_o = {dot_fin, dot_valid};
  assign m_axis_tlast_o = dot_last;

endmodule

@@ rtl/core/dcpg_fifo.sv @@
// ----------------------------------------------------------------------------
// dcpg_fifo
// small job queue between the iteration front and the dot back end
// ----------------------------------------------------------------------------
module dcpg_fifo import dcpg_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(Depth - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(Depth);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               push, pop;

  assign wr_ready_o = (cnt_q != CntFull);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/core/dcpg_front.sv @@
// ----------------------------------------------------------------------------
// dcpg_front
// accepts start and step words, runs one midpoint iteration per start word
// or per step word while busy, and queues a job describing the dots to emit
// ----------------------------------------------------------------------------
module dcpg_front import dcpg_pkg::*; #(
  parameter int CoordBits = CoordBitsDef,
  parameter int JobBits   = 2 * CoordBits + 2 * OffsetBits + FlagBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_mode_i,
  input  logic [CoordBits-1:0]  in_center_x_i,
  input  logic [CoordBits-1:0]  in_center_y_i,
  input  logic [RadiusBits-1:0] in_radius_i,
  input  logic [StyleBits-1:0]  in_line_style_i,
  input  logic               in_draw_color_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output logic [JobBits-1:0] job_data_o
);

  typedef struct packed {
    logic [CoordBits-1:0]  cx;
    logic [CoordBits-1:0]  cy;
    logic [OffsetBits-1:0] ox;
    logic [OffsetBits-1:0] oy;
    job_flags_t            flags;
  } job_t;

  // held circle state
  logic [CoordBits-1:0]  cx_q, cy_q;
  logic [OffsetBits-1:0] x_q, y_q;
  logic [1:0]            x3_q;   // x modulo 3
  logic [DecBits-1:0]    dec_q;
  logic [StyleBits-1:0]  style_q;
  logic                  color_q;
  logic                  busy_q;

  // operands of the iteration run for this word
  logic                  accept, start, run;
  logic [CoordBits-1:0]  it_cx, it_cy;
  logic [OffsetBits-1:0] it_x, it_y;
  logic [1:0]            it_x3;
  logic [DecBits-1:0]    it_d;
  logic [StyleBits-1:0]  it_style;
  logic                  it_color;

  logic [DecBits-1:0]    x_ext, y_ext, d_next;
  logic [OffsetBits:0]   nx, ny;
  logic                  fin, pass;
  job_t                  job;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i && job_ready_i;
  assign start       = (in_mode_i == ModeStart);
  assign run         = start || busy_q;

  // start loads fresh operands, step reuses the held ones
  always_comb begin
    if (start) begin
      it_cx    = in_center_x_i;
      it_cy    = in_center_y_i;
      it_x     = '0;
      it_y     = OffsetBits'(in_radius_i);
      it_x3    = 2'd0;
      it_d     = DecBits'(3) - {(DecBits - RadiusBits - 1)'(0), in_radius_i, 1'b0};
      it_style = in_line_style_i;
      it_color = in_draw_color_i;
    end else begin
      it_cx    = cx_q;
      it_cy    = cy_q;
      it_x     = x_q;
      it_y     = y_q;
      it_x3    = x3_q;
      it_d     = dec_q;
      it_style = style_q;
      it_color = color_q;
    end
  end

  // midpoint decision update
  assign x_ext = DecBits'(it_x);
  assign y_ext = DecBits'(it_y);

  always_comb begin
    if (it_d[DecBits-1]) begin
      d_next = it_d + (x_ext << 2) + DecBits'(6);
      ny     = {1'b0, it_y};
    end else begin
      d_next = it_d + ((x_ext - y_ext) << 2) + DecBits'(10);
      ny     = {1'b0, it_y} - 1'b1;
    end
    nx  = {1'b0, it_x} + 1'b1;
    fin = ($signed(nx) > $signed(ny));
  end

  // line style filter on the current x
  always_comb begin
    unique case (it_style)
      StyleFull:  pass = 1'b1;
      StyleEven:  pass = !it_x[0];
      StyleOdd:   pass = it_x[0];
      StyleThird: pass = (it_x3 == 2'd0);
      default:    pass = 1'b1;
    endcase
  end

  // job word, a step while idle gives an empty finished job
  always_comb begin
    job.cx          = it_cx;
    job.cy          = it_cy;
    job.ox          = it_x;
    job.oy          = it_y;
    job.flags.dot   = run && pass;
    job.flags.fin   = run ? fin : 1'b1;
    job.flags.color = it_color;
  end

  assign job_data_o = job;

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      x_q     <= '0;
      y_q     <= '0;
      x3_q    <= '0;
      dec_q   <= '0;
      style_q <= '0;
      color_q <= 1'b0;
      busy_q  <= 1'b0;
    end else if (accept && run) begin
      cx_q    <= it_cx;
      cy_q    <= it_cy;
      x_q     <= nx[OffsetBits-1:0];
      y_q     <= ny[OffsetBits-1:0];
      x3_q    <= (it_x3 == 2'd2) ? 2'd0 : it_x3 + 2'd1;
      dec_q   <= d_next;
      style_q <= it_style;
      color_q <= it_color;
      busy_q  <= !fin;
    end
  end

endmodule

@@ rtl/core/dcpg_back.sv @@
// ----------------------------------------------------------------------------
// dcpg_back
// takes queued jobs and emits their dots one word per cycle while the
// output is not stalled, through an output register
// ----------------------------------------------------------------------------
module dcpg_back import dcpg_pkg::*; #(
  parameter int CoordBits = CoordBitsDef,
  parameter int JobBits   = 2 * CoordBits + 2 * OffsetBits + FlagBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  logic [JobBits-1:0]   job_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CoordBits-1:0] out_dot_x_o,
  output logic [CoordBits-1:0] out_dot_y_o,
  output logic                 out_dot_color_o,
  output logic                 out_dot_valid_o,
  output logic                 out_last_o,
  output logic                 out_finished_o
);

  typedef struct packed {
    logic [CoordBits-1:0]  cx;
    logic [CoordBits-1:0]  cy;
    logic [OffsetBits-1:0] ox;
    logic [OffsetBits-1:0] oy;
    job_flags_t            flags;
  } job_t;

  localparam logic [BeatBits-1:0] BeatLast = BeatBits'(DotsPerIter - 1);

  job_t                job_q;
  logic                have_q;
  logic [BeatBits-1:0] beat_q;

  logic                load, beat_last, take;
  logic [CoordBits-1:0] off_a, off_b, bx, by;

  logic                 valid_q;
  logic [CoordBits-1:0] dx_q, dy_q;
  logic                 color_q, dot_q, last_q, fin_q;

  assign load      = have_q && (!valid_q || out_ready_i);
  assign beat_last = !job_q.flags.dot || (beat_q == BeatLast);
  assign take      = !have_q || (load && beat_last);
  assign job_ready_o = take;

  // symmetric point for the current beat: bit 2 swaps the offsets,
  // bit 1 mirrors the column and bit 0 mirrors the row
  always_comb begin
    if (beat_q[2]) begin
      off_a = CoordBits'(job_q.oy);
      off_b = CoordBits'(job_q.ox);
    end else begin
      off_a = CoordBits'(job_q.ox);
      off_b = CoordBits'(job_q.oy);
    end
    bx = beat_q[1] ? job_q.cx - off_a : job_q.cx + off_a;
    by = beat_q[0] ? job_q.cy - off_b : job_q.cy + off_b;
  end

  // current job and beat counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      beat_q <= '0;
    end else if (take) begin
      have_q <= job_valid_i;
      beat_q <= '0;
    end else if (load) begin
      beat_q <= beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && job_valid_i) begin
      job_q <= job_t'(job_data_i);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dx_q    <= job_q.flags.dot ? bx : '0;
      dy_q    <= job_q.flags.dot ? by : '0;
      color_q <= job_q.flags.dot && job_q.flags.color;
      dot_q   <= job_q.flags.dot;
      last_q  <= beat_last;
      fin_q   <= job_q.flags.fin;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_dot_x_o     = dx_q;
  assign out_dot_y_o     = dy_q;
  assign out_dot_color_o = color_q;
  assign out_dot_valid_o = dot_q;
  assign out_last_o      = last_q;
  assign out_finished_o  = fin_q;

endmodule

@@ rtl/core/dcpg_checker.sv @@
// ----------------------------------------------------------------------------
// dcpg_checker
// port level checks of the dotted circle point generator result stream
// ----------------------------------------------------------------------------
`include "dotted_circle_point_generator_macros.svh"

module dcpg_checker import dcpg_pkg::*; #(
  parameter int OutDataW = 24
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic [1:0]          m_axis_tuser_o,
  input logic                m_axis_tlast_o
);

  logic                out_acc, out_stall, out_empty, empty_ok;
  logic                out_mid, out_vdot, out_fin;
  logic [OutDataW+2:0] out_word;

  assign out_acc   = m_axis_tvalid_o && m_axis_tready_i;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word  = {m_axis_tlast_o, m_axis_tuser_o, m_axis_tdata_o};
  assign out_empty = m_axis_tvalid_o && !m_axis_tuser_o[0];
  assign empty_ok  = m_axis_tlast_o && (m_axis_tdata_o == '0);
  assign out_mid   = out_acc && !m_axis_tlast_o;
  assign out_vdot  = m_axis_tvalid_o && m_axis_tuser_o[0];
  assign out_fin   = m_axis_tuser_o[1];

  // a stalled result word holds
  `DCPG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_word))

  // a word without a dot ends its item and carries no coordinates
  `DCPG_ASSERT_SAME(a_empty_word, clk_i, rst_ni, out_empty, empty_ok)

  // dots of one iteration follow back to back with the same finished flag
  `DCPG_ASSERT_NEXT(a_burst_cont, clk_i, rst_ni, out_mid, out_vdot && (out_fin == $past(out_fin)))

endmodule

bind dotted_circle_point_generator dcpg_checker #(
  .OutDataW (OutDataW)
) u_dcpg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
